>>> rtl/b2d_pkg.sv
package b2d_pkg;

  localparam int VALUE_W = 16;
  localparam int COUNT_W = 3;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 6;
  localparam int PROD_W  = 2 * VALUE_W;

  // x / 10 == (x * 52429) >> 19, exact for every 16-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 16'd52429;
  localparam int                 RECIP_SHIFT = 19;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

endpackage

>>> rtl/b2d_div_stage.sv
module b2d_div_stage #(
  parameter int MAX_DIGITS = 5,
  parameter int IDX        = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  b2d_pkg::value_t                       value_in,
  input  b2d_pkg::count_t                       count_in,
  input  logic [MAX_DIGITS*b2d_pkg::DIGIT_W-1:0] digits_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output b2d_pkg::value_t                       value_out,
  output b2d_pkg::count_t                       count_out,
  output logic [MAX_DIGITS*b2d_pkg::DIGIT_W-1:0] digits_out
);

  logic [b2d_pkg::PROD_W-1:0]               prod;
  b2d_pkg::value_t                          quot;
  b2d_pkg::value_t                          rem_full;
  logic [MAX_DIGITS*b2d_pkg::DIGIT_W-1:0]   digits_next;
  logic                                     load;

  // divide by ten through the reciprocal, remainder by shift and subtract
  assign prod     = b2d_pkg::PROD_W'(value_in) * b2d_pkg::PROD_W'(b2d_pkg::RECIP_TEN);
  assign quot     = b2d_pkg::VALUE_W'(prod[b2d_pkg::PROD_W-1:b2d_pkg::RECIP_SHIFT]);
  assign rem_full = value_in - (quot << 3) - (quot << 1);

  always_comb begin
    digits_next = digits_in;
    digits_next[IDX*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] = rem_full[b2d_pkg::DIGIT_W-1:0];
  end

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_out  <= quot;
      count_out  <= count_in;
      digits_out <= digits_next;
    end
  end

endmodule

>>> rtl/b2d_emit.sv
module b2d_emit #(
  parameter int MAX_DIGITS = 5
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  b2d_pkg::count_t                       count_in,
  input  logic [MAX_DIGITS*b2d_pkg::DIGIT_W-1:0] digits_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output b2d_pkg::char_t                        ascii_char,
  output logic                                  last_char
);

  localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  b2d_pkg::digit_t   dig [MAX_DIGITS];
  logic [POS_W-1:0]  pos;
  logic              load;
  logic              take;
  b2d_pkg::count_t   count_m1;

  assign last_char = (pos == '0);
  assign take      = out_valid && out_ready;
  assign in_ready  = !out_valid || (out_ready && last_char);
  assign load      = in_valid && in_ready;
  assign count_m1  = count_in - b2d_pkg::COUNT_W'(1);

  assign ascii_char = b2d_pkg::ASCII_ZERO
                    + b2d_pkg::CHAR_W'(dig[pos]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (take && last_char) begin
      out_valid <= 1'b0;
    end
  end

  // most significant requested digit first, down to the units
  always_ff @(posedge clk) begin
    if (load) begin
      pos <= POS_W'(count_m1);
      for (int i = 0; i < MAX_DIGITS; i++) begin
        dig[i] <= digits_in[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W];
      end
    end else if (take) begin
      pos <= pos - POS_W'(1);
    end
  end

endmodule

>>> rtl/binary_to_decimal_ascii_digits.sv
// one divide-by-ten stage per digit, then a serialiser sending one character a cycle
// while char_ready is high; the serialiser takes a new item only as the last
// character of the previous one is taken, and the divide stages take an item
// every cycle unless held by the stage after them
// reset: synchronous, active high, clears every stage valid and the serialiser valid
module binary_to_decimal_ascii_digits #(
  parameter int MAX_DIGITS = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  b2d_pkg::value_t value,
  input  b2d_pkg::count_t digit_count,
  output logic            char_valid,
  input  logic            char_ready,
  output b2d_pkg::char_t  ascii_char,
  output logic            last_char
);

  localparam int DIGS_W = MAX_DIGITS * b2d_pkg::DIGIT_W;

  logic              vld_link [MAX_DIGITS+1];
  logic              rdy_link [MAX_DIGITS+1];
  b2d_pkg::value_t   val_link [MAX_DIGITS];
  b2d_pkg::count_t   cnt_link [MAX_DIGITS+1];
  logic [DIGS_W-1:0] dig_link [MAX_DIGITS+1];

  b2d_pkg::count_t   count_clamped;

  // zero count raised to one, counts above the limit cut to the limit
  always_comb begin
    priority if (digit_count == '0) begin
      count_clamped = b2d_pkg::COUNT_W'(1);
    end else if (digit_count > b2d_pkg::COUNT_W'(MAX_DIGITS)) begin
      count_clamped = b2d_pkg::COUNT_W'(MAX_DIGITS);
    end else begin
      count_clamped = digit_count;
    end
  end

  assign vld_link[0] = item_valid;
  assign item_ready  = rdy_link[0];
  assign val_link[0] = value;
  assign cnt_link[0] = count_clamped;
  assign dig_link[0] = '0;

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_stage
    if (g == MAX_DIGITS - 1) begin : g_last
      b2d_div_stage #(.MAX_DIGITS(MAX_DIGITS), .IDX(g)) u_stage (
        .clk        (clk),
        .rst        (rst),
        .in_valid   (vld_link[g]),
        .in_ready   (rdy_link[g]),
        .value_in   (val_link[g]),
        .count_in   (cnt_link[g]),
        .digits_in  (dig_link[g]),
        .out_valid  (vld_link[g+1]),
        .out_ready  (rdy_link[g+1]),
        .value_out  (),
        .count_out  (cnt_link[g+1]),
        .digits_out (dig_link[g+1])
      );
    end else begin : g_mid
      b2d_div_stage #(.MAX_DIGITS(MAX_DIGITS), .IDX(g)) u_stage (
        .clk        (clk),
        .rst        (rst),
        .in_valid   (vld_link[g]),
        .in_ready   (rdy_link[g]),
        .value_in   (val_link[g]),
        .count_in   (cnt_link[g]),
        .digits_in  (dig_link[g]),
        .out_valid  (vld_link[g+1]),
        .out_ready  (rdy_link[g+1]),
        .value_out  (val_link[g+1]),
        .count_out  (cnt_link[g+1]),
        .digits_out (dig_link[g+1])
      );
    end
  end

  b2d_emit #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (vld_link[MAX_DIGITS]),
    .in_ready   (rdy_link[MAX_DIGITS]),
    .count_in   (cnt_link[MAX_DIGITS]),
    .digits_in  (dig_link[MAX_DIGITS]),
    .out_valid  (char_valid),
    .out_ready  (char_ready),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

endmodule

>>> rtl/b2d_checker.sv
module b2d_checker (
  input logic           clk,
  input logic           rst,
  input logic           char_valid,
  input logic           char_ready,
  input b2d_pkg::char_t ascii_char,
  input logic           last_char
);

  // a stalled character holds
  a_char_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(ascii_char) && $stable(last_char))
    else $error("stalled character changed");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (ascii_char >= 6'd48) && (ascii_char <= 6'd57))
    else $error("character outside decimal digits");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !char_valid)
    else $error("character shown right after reset");

  // no character is shown before any item could have passed through the divide stages
  a_no_early_char: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !char_valid)
    else $error("character before any item could arrive");

endmodule

bind binary_to_decimal_ascii_digits b2d_checker u_b2d_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .ascii_char (ascii_char),
  .last_char  (last_char)
);
